// ===== rtl/ttmd_pkg.sv =====
`timescale 1ns / 1ps
`default_nettype none

package ttmd_pkg;

    localparam int TRACKS_DEF      = 9;
    localparam int DELAY_DEPTH_DEF = 32;
    localparam int GUARD_DEF       = 30;

    localparam int MAX_TRACKS = 16;
    localparam int RAW_W      = 16;
    localparam int SEL_W      = 4;
    localparam int MAP_W      = 36;
    localparam int MAP_EXT_W  = SEL_W * MAX_TRACKS;
    localparam int GLITCH_W   = 5;
    localparam int RUN_W      = 6;
    localparam int GUARD_W    = 5;
    localparam int CFG_IDX_W  = 1;
    localparam int QUEUE_DEPTH = 2;

    localparam logic [MAP_W-1:0]     MAP_RESET = 36'h876543210;
    localparam logic [RUN_W-1:0]     RUN_SAT   = 6'd63;

    localparam logic [CFG_IDX_W-1:0] REG_CHANNEL_MAP = 1'd0;
    localparam logic [CFG_IDX_W-1:0] REG_GLITCH_MAX  = 1'd1;

    // one classified sample handed from the front end to the back end
    typedef struct packed {
        logic [MAX_TRACKS-1:0]               sample;
        logic [MAX_TRACKS-1:0][GLITCH_W-1:0] refill_len;
        logic                                last;
    } ttmd_rec_t;

endpackage

`default_nettype wire

// ===== rtl/ttmd_front.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ttmd_front #(
    parameter int TRACKS = ttmd_pkg::TRACKS_DEF,
    parameter int GUARD  = ttmd_pkg::GUARD_DEF
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [ttmd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ttmd_pkg::MAP_W-1:0]     cfg_data,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [ttmd_pkg::RAW_W-1:0]     s_tdata,
    input  wire logic                           s_tlast,
    input  wire logic                           q_ready,
    output logic                                q_push,
    output ttmd_pkg::ttmd_rec_t                 q_rec
);

    logic [ttmd_pkg::MAP_W-1:0]    chan_map_reg;
    logic [ttmd_pkg::GLITCH_W-1:0] refill_limit_reg;
    logic [TRACKS-1:0]             prev_reg, prev_next;
    logic [TRACKS-1:0]             open_reg, open_next;
    logic [TRACKS-1:0][ttmd_pkg::RUN_W-1:0] run_len_reg, run_len_next;
    logic [ttmd_pkg::GUARD_W-1:0]  guard_cnt_reg, guard_cnt_next;

    logic [ttmd_pkg::MAP_EXT_W-1:0] map_ext;
    logic [TRACKS-1:0]              mapped;
    logic [TRACKS-1:0]              cur;
    logic                           in_guard;
    logic                           accept;

    assign cfg_ready = 1'b1;
    assign s_tready  = q_ready;
    assign accept    = s_tvalid && q_ready;
    assign q_push    = accept;

    // fields above the register read as zero, i.e. raw bit 0
    assign map_ext  = {{(ttmd_pkg::MAP_EXT_W - ttmd_pkg::MAP_W){1'b0}}, chan_map_reg};
    assign in_guard = guard_cnt_reg < ttmd_pkg::GUARD_W'(GUARD);

    always_comb begin
        for (int t = 0; t < TRACKS; t++) begin
            mapped[t] = s_tdata[map_ext[ttmd_pkg::SEL_W*t +: ttmd_pkg::SEL_W]];
        end
        cur = in_guard ? '1 : mapped;
    end

    always_comb begin
        q_rec              = '0;
        q_rec.sample[TRACKS-1:0] = cur;
        q_rec.last         = s_tlast;
        open_next          = open_reg;
        run_len_next       = run_len_reg;
        for (int t = 0; t < TRACKS; t++) begin
            if (prev_reg[t] && !cur[t]) begin
                open_next[t]    = 1'b1;
                run_len_next[t] = ttmd_pkg::RUN_W'(1);
            end else if (!cur[t]) begin
                if (open_reg[t] && run_len_reg[t] < ttmd_pkg::RUN_SAT) begin
                    run_len_next[t] = run_len_reg[t] + ttmd_pkg::RUN_W'(1);
                end
            end else if (!prev_reg[t] && open_reg[t]) begin
                // rising edge closes the run; refill only short ones
                if (run_len_reg[t] <= ttmd_pkg::RUN_W'(refill_limit_reg)) begin
                    q_rec.refill_len[t] = run_len_reg[t][ttmd_pkg::GLITCH_W-1:0];
                end
                open_next[t]    = 1'b0;
                run_len_next[t] = '0;
            end
        end
        prev_next      = cur;
        guard_cnt_next = in_guard ? guard_cnt_reg + ttmd_pkg::GUARD_W'(1) : guard_cnt_reg;
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            chan_map_reg     <= ttmd_pkg::MAP_RESET;
            refill_limit_reg <= '0;
            prev_reg         <= '1;
            open_reg         <= '0;
            run_len_reg      <= '0;
            guard_cnt_reg    <= '0;
        end else begin
            if (cfg_valid) begin
                unique case (cfg_index)
                    ttmd_pkg::REG_CHANNEL_MAP: chan_map_reg <= cfg_data;
                    ttmd_pkg::REG_GLITCH_MAX:
                        refill_limit_reg <= cfg_data[ttmd_pkg::GLITCH_W-1:0];
                    default: ;
                endcase
            end
            if (accept) begin
                if (s_tlast) begin
                    prev_reg      <= '1;
                    open_reg      <= '0;
                    run_len_reg   <= '0;
                    guard_cnt_reg <= '0;
                end else begin
                    prev_reg      <= prev_next;
                    open_reg      <= open_next;
                    run_len_reg   <= run_len_next;
                    guard_cnt_reg <= guard_cnt_next;
                end
            end
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ttmd_queue.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ttmd_queue (
    input  wire logic          aclk,
    input  wire logic          aresetn,
    input  wire logic          push,
    input  wire ttmd_pkg::ttmd_rec_t push_rec,
    output logic               push_ready,
    input  wire logic          pop,
    output logic               pop_valid,
    output ttmd_pkg::ttmd_rec_t pop_rec
);

    localparam int PTR_W = $clog2(ttmd_pkg::QUEUE_DEPTH);
    localparam int CNT_W = $clog2(ttmd_pkg::QUEUE_DEPTH + 1);

    ttmd_pkg::ttmd_rec_t mem_reg [ttmd_pkg::QUEUE_DEPTH];
    logic [PTR_W-1:0] wr_ptr_reg, wr_ptr_next;
    logic [PTR_W-1:0] rd_ptr_reg, rd_ptr_next;
    logic [CNT_W-1:0] cnt_reg, cnt_next;

    assign push_ready = cnt_reg != CNT_W'(ttmd_pkg::QUEUE_DEPTH);
    assign pop_valid  = cnt_reg != '0;
    assign pop_rec    = mem_reg[rd_ptr_reg];

    always_comb begin
        wr_ptr_next = wr_ptr_reg;
        rd_ptr_next = rd_ptr_reg;
        cnt_next    = cnt_reg;
        if (push) begin
            wr_ptr_next = (wr_ptr_reg == PTR_W'(ttmd_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : wr_ptr_reg + PTR_W'(1);
        end
        if (pop) begin
            rd_ptr_next = (rd_ptr_reg == PTR_W'(ttmd_pkg::QUEUE_DEPTH - 1)) ?
                          '0 : rd_ptr_reg + PTR_W'(1);
        end
        if (push && !pop) begin
            cnt_next = cnt_reg + CNT_W'(1);
        end else if (pop && !push) begin
            cnt_next = cnt_reg - CNT_W'(1);
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            wr_ptr_reg <= '0;
            rd_ptr_reg <= '0;
            cnt_reg    <= '0;
        end else begin
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
            cnt_reg    <= cnt_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            mem_reg[wr_ptr_reg] <= push_rec;
        end
    end

endmodule

`default_nettype wire

// ===== rtl/ttmd_back.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ttmd_back #(
    parameter int TRACKS      = ttmd_pkg::TRACKS_DEF,
    parameter int DELAY_DEPTH = ttmd_pkg::DELAY_DEPTH_DEF,
    parameter int DATA_W      = ((TRACKS + 7) / 8) * 8
) (
    input  wire logic              aclk,
    input  wire logic              aresetn,
    input  wire logic              q_valid,
    input  wire ttmd_pkg::ttmd_rec_t q_rec,
    output logic                   q_pop,
    output logic                   m_tvalid,
    input  wire logic              m_tready,
    output logic [DATA_W-1:0]      m_tdata,
    output logic                   m_tlast
);

    localparam int POS_W = $clog2(DELAY_DEPTH);
    localparam int CNT_W = $clog2(DELAY_DEPTH + 1);
    localparam int CMP_W = 8;

    logic [TRACKS-1:0] line_reg [DELAY_DEPTH];
    logic [TRACKS-1:0] line_next [DELAY_DEPTH];
    logic [TRACKS-1:0] line_mod [DELAY_DEPTH];
    logic [CNT_W-1:0]  fill_reg, fill_next;
    logic [CNT_W-1:0]  rem_reg, rem_next;
    logic              drain_reg, drain_next;
    logic              out_valid_reg, out_valid_next;
    logic [TRACKS-1:0] out_data_reg, out_data_next;
    logic              out_last_reg, out_last_next;

    logic              out_free;
    logic [POS_W-1:0]  pos;
    logic              full;
    logic [POS_W-1:0]  age;

    assign m_tvalid = out_valid_reg;
    assign m_tdata  = DATA_W'(out_data_reg);
    assign m_tlast  = out_last_reg;

    assign out_free = !out_valid_reg || m_tready;
    assign q_pop    = q_valid && !drain_reg && out_free;
    assign pos      = (fill_reg >= CNT_W'(DELAY_DEPTH - 1)) ?
                      POS_W'(DELAY_DEPTH - 1) : fill_reg[POS_W-1:0];
    assign full     = pos == POS_W'(DELAY_DEPTH - 1);

    // push the new sample, then refill the last len held samples of each closed run
    always_comb begin
        age = '0;
        for (int j = 0; j < DELAY_DEPTH; j++) begin
            line_mod[j] = (POS_W'(j) == pos) ? q_rec.sample[TRACKS-1:0] : line_reg[j];
            if (POS_W'(j) < pos) begin
                age = pos - POS_W'(j);
                for (int t = 0; t < TRACKS; t++) begin
                    if (CMP_W'(age) <= CMP_W'(q_rec.refill_len[t])) begin
                        line_mod[j][t] = 1'b1;
                    end
                end
            end
        end
    end

    always_comb begin
        for (int j = 0; j < DELAY_DEPTH; j++) begin
            line_next[j] = line_reg[j];
        end
        fill_next      = fill_reg;
        rem_next       = rem_reg;
        drain_next     = drain_reg;
        out_valid_next = out_valid_reg && !m_tready;
        out_data_next  = out_data_reg;
        out_last_next  = out_last_reg;
        if (q_pop) begin
            if (q_rec.last) begin
                for (int j = 0; j < DELAY_DEPTH; j++) begin
                    line_next[j] = line_mod[j];
                end
                drain_next = 1'b1;
                rem_next   = CNT_W'(pos) + CNT_W'(1);
            end else if (full) begin
                out_valid_next = 1'b1;
                out_data_next  = line_mod[0];
                out_last_next  = 1'b0;
                for (int j = 0; j < DELAY_DEPTH - 1; j++) begin
                    line_next[j] = line_mod[j + 1];
                end
                fill_next = CNT_W'(pos);
            end else begin
                for (int j = 0; j < DELAY_DEPTH; j++) begin
                    line_next[j] = line_mod[j];
                end
                fill_next = CNT_W'(pos) + CNT_W'(1);
            end
        end else if (drain_reg && out_free) begin
            out_valid_next = 1'b1;
            out_data_next  = line_reg[0];
            out_last_next  = rem_reg == CNT_W'(1);
            for (int j = 0; j < DELAY_DEPTH - 1; j++) begin
                line_next[j] = line_reg[j + 1];
            end
            rem_next = rem_reg - CNT_W'(1);
            if (rem_reg == CNT_W'(1)) begin
                drain_next = 1'b0;
                fill_next  = '0;
            end
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            fill_reg      <= '0;
            rem_reg       <= '0;
            drain_reg     <= 1'b0;
            out_valid_reg <= 1'b0;
            out_last_reg  <= 1'b0;
        end else begin
            fill_reg      <= fill_next;
            rem_reg       <= rem_next;
            drain_reg     <= drain_next;
            out_valid_reg <= out_valid_next;
            out_last_reg  <= out_last_next;
        end
    end

    always_ff @(posedge aclk) begin
        out_data_reg <= out_data_next;
        for (int j = 0; j < DELAY_DEPTH; j++) begin
            line_reg[j] <= line_next[j];
        end
    end

endmodule

`default_nettype wire

// ===== rtl/tape_track_map_and_deglitch_unit.sv =====
// latency: a sample leaves once DELAY_DEPTH-1 later samples have entered; the transaction that
//   pushes it out passes the queue stage, and the sample then leaves through the output register
// throughput: one sample per cycle while the sink keeps up and no drain is running
// a tlast sample drains n results, one per cycle unless stalled, n = samples held (<= DELAY_DEPTH)
// reset (aresetn low, synchronous): clears run tracking, guard count, fill count,
//   queue and output; the channel map and the refill limit return to their defaults
`timescale 1ns / 1ps
`default_nettype none

module tape_track_map_and_deglitch_unit #(
    parameter int TRACKS      = ttmd_pkg::TRACKS_DEF,
    parameter int DELAY_DEPTH = ttmd_pkg::DELAY_DEPTH_DEF,
    parameter int GUARD       = ttmd_pkg::GUARD_DEF,
    parameter int DATA_W      = ((TRACKS + 7) / 8) * 8
) (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    output logic                                cfg_ready,
    input  wire logic [ttmd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ttmd_pkg::MAP_W-1:0]     cfg_data,
    input  wire logic                           s_tvalid,
    output logic                                s_tready,
    input  wire logic [ttmd_pkg::RAW_W-1:0]     s_tdata,   // [15:0] raw_sample
    input  wire logic                           s_tlast,   // end_of_stream
    output logic                                m_tvalid,
    input  wire logic                           m_tready,
    output logic [DATA_W-1:0]                   m_tdata,   // [TRACKS-1:0] clean_sample, rest zero
    output logic                                m_tlast    // final_result
);

    ttmd_pkg::ttmd_rec_t push_rec;
    ttmd_pkg::ttmd_rec_t pop_rec;
    logic                q_push;
    logic                q_ready;
    logic                q_pop;
    logic                q_valid;

    ttmd_front #(
        .TRACKS (TRACKS),
        .GUARD  (GUARD)
    ) u_front (
        .aclk      (aclk),
        .aresetn   (aresetn),
        .cfg_valid (cfg_valid),
        .cfg_ready (cfg_ready),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .s_tvalid  (s_tvalid),
        .s_tready  (s_tready),
        .s_tdata   (s_tdata),
        .s_tlast   (s_tlast),
        .q_ready   (q_ready),
        .q_push    (q_push),
        .q_rec     (push_rec)
    );

    ttmd_queue u_queue (
        .aclk       (aclk),
        .aresetn    (aresetn),
        .push       (q_push),
        .push_rec   (push_rec),
        .push_ready (q_ready),
        .pop        (q_pop),
        .pop_valid  (q_valid),
        .pop_rec    (pop_rec)
    );

    ttmd_back #(
        .TRACKS      (TRACKS),
        .DELAY_DEPTH (DELAY_DEPTH),
        .DATA_W      (DATA_W)
    ) u_back (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .q_valid  (q_valid),
        .q_rec    (pop_rec),
        .q_pop    (q_pop),
        .m_tvalid (m_tvalid),
        .m_tready (m_tready),
        .m_tdata  (m_tdata),
        .m_tlast  (m_tlast)
    );

endmodule

`default_nettype wire

// ===== rtl/ttmd_checker.sv =====
`timescale 1ns / 1ps
`default_nettype none

module ttmd_checker #(
    parameter int TRACKS = ttmd_pkg::TRACKS_DEF,
    parameter int DATA_W = ((TRACKS + 7) / 8) * 8
) (
    input wire logic              aclk,
    input wire logic              aresetn,
    input wire logic              m_tvalid,
    input wire logic              m_tready,
    input wire logic [DATA_W-1:0] m_tdata,
    input wire logic              m_tlast
);

    // a stalled result transaction holds
    a_out_hold: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid && !m_tready |=> m_tvalid && $stable(m_tdata) && $stable(m_tlast))
        else $error("result changed while stalled");

    // reset empties the output register
    a_reset_clears: assert property (@(posedge aclk)
        $rose(aresetn) |-> !m_tvalid)
        else $error("result valid straight after reset");

    // padding above the track bits stays zero
    a_pad_zero: assert property (@(posedge aclk) disable iff (!aresetn)
        m_tvalid |-> (m_tdata >> TRACKS) == '0)
        else $error("padding bits set in result");

endmodule

bind tape_track_map_and_deglitch_unit ttmd_checker #(
    .TRACKS (TRACKS),
    .DATA_W (DATA_W)
) u_ttmd_checker (
    .aclk     (aclk),
    .aresetn  (aresetn),
    .m_tvalid (m_tvalid),
    .m_tready (m_tready),
    .m_tdata  (m_tdata),
    .m_tlast  (m_tlast)
);

`default_nettype wire

// ===== sim/track_stream_checker.sv =====
`timescale 1ns / 1ps

module track_stream_checker (
    input  wire logic                           aclk,
    input  wire logic                           aresetn,
    input  wire logic                           cfg_valid,
    input  wire logic                           cfg_ready,
    input  wire logic [ttmd_pkg::CFG_IDX_W-1:0] cfg_index,
    input  wire logic [ttmd_pkg::MAP_W-1:0]     cfg_data,
    input  wire logic                           s_tvalid,
    input  wire logic                           s_tready,
    input  wire logic [ttmd_pkg::RAW_W-1:0]     s_tdata,   // [15:0] raw_sample
    input  wire logic                           s_tlast,   // end_of_stream
    input  wire logic                           m_tvalid,
    input  wire logic                           m_tready,
    input  wire logic [15:0]                    m_tdata,   // [8:0] clean_sample, rest zero
    input  wire logic                           m_tlast,   // final_result
    output int                                  mismatches,
    output int                                  awaited,
    output int                                  words_checked,
    output int                                  refills
);

    localparam int TRACKS = ttmd_pkg::TRACKS_DEF;
    localparam int DEPTH  = ttmd_pkg::DELAY_DEPTH_DEF;
    localparam int GUARD  = ttmd_pkg::GUARD_DEF;

    typedef struct packed {
        logic [TRACKS-1:0] tracks;
        logic              fin;
    } track_word_t;

    track_word_t       expected_words[$];

    logic [ttmd_pkg::MAP_W-1:0]    track_map;
    logic [ttmd_pkg::GLITCH_W-1:0] glitch_limit;
    logic [TRACKS-1:0]             prev_tracks;
    logic [TRACKS-1:0]             run_open;
    logic [ttmd_pkg::RUN_W-1:0]    run_len [TRACKS];
    logic [TRACKS-1:0]             held [DEPTH];
    int                            held_count;
    int                            guard_seen;

    function automatic void clear_tracking();
        prev_tracks = '1;
        run_open    = '0;
        for (int t = 0; t < TRACKS; t++) run_len[t] = '0;
        held_count = 0;
        guard_seen = 0;
    endfunction

    task automatic report(input string what, input logic [15:0] got, input logic [15:0] want);
        $display("error at %0t: %s got %0h, want %0h", $time, what, got, want);
        mismatches++;
    endtask

    task automatic map_and_deglitch(input logic [ttmd_pkg::RAW_W-1:0] raw, input logic last);
        logic [TRACKS-1:0]          cur;
        logic [ttmd_pkg::SEL_W-1:0] src;
        int                         n;
        if (guard_seen < GUARD) begin
            cur = '1;
            guard_seen++;
        end else begin
            for (int t = 0; t < TRACKS; t++) begin
                src    = track_map[ttmd_pkg::SEL_W*t +: ttmd_pkg::SEL_W];
                cur[t] = raw[src];
            end
        end

        // the line never holds DEPTH samples between transactions
        n = (held_count >= DEPTH) ? DEPTH - 1 : held_count;
        held[n] = cur;
        n++;

        for (int t = 0; t < TRACKS; t++) begin
            if (prev_tracks[t] && !cur[t]) begin
                run_open[t] = 1'b1;
                run_len[t]  = ttmd_pkg::RUN_W'(1);
            end else if (!cur[t]) begin
                if (run_open[t] && run_len[t] < ttmd_pkg::RUN_SAT) run_len[t]++;
            end else if (!prev_tracks[t] && run_open[t]) begin
                if (run_len[t] <= glitch_limit) begin
                    // refill the low run behind the rising edge
                    for (int i = 1; i <= run_len[t] && i < n; i++) held[n-1-i][t] = 1'b1;
                    refills++;
                end
                run_open[t] = 1'b0;
                run_len[t]  = '0;
            end
        end
        prev_tracks = cur;

        if (last) begin
            for (int i = 0; i < n; i++) expected_words.push_back({held[i], i == n - 1});
            clear_tracking();
        end else begin
            if (n >= DEPTH) begin
                expected_words.push_back({held[0], 1'b0});
                for (int i = 0; i < n - 1; i++) held[i] = held[i+1];
                n--;
            end
            held_count = n;
        end
    endtask

    always @(posedge aclk) begin
        track_word_t want;
        if (!aresetn) begin
            track_map     = ttmd_pkg::MAP_RESET;
            glitch_limit  = '0;
            clear_tracking();
            expected_words.delete();
            mismatches    = 0;
            words_checked = 0;
            refills       = 0;
        end else begin
            if (cfg_valid && cfg_ready) begin
                if (cfg_index == ttmd_pkg::REG_CHANNEL_MAP) track_map = cfg_data;
                else glitch_limit = cfg_data[ttmd_pkg::GLITCH_W-1:0];
            end
            if (s_tvalid && s_tready) map_and_deglitch(s_tdata, s_tlast);
            if (m_tvalid && m_tready) begin
                if (expected_words.size() == 0) begin
                    report("result transaction with nothing expected", m_tdata, '0);
                end else begin
                    want = expected_words.pop_front();
                    words_checked++;
                    if (m_tdata[TRACKS-1:0] !== want.tracks)
                        report("clean_sample", 16'(m_tdata[TRACKS-1:0]), 16'(want.tracks));
                    if (m_tdata[15:TRACKS] !== '0)
                        report("tdata padding", 16'(m_tdata[15:TRACKS]), '0);
                    if (m_tlast !== want.fin)
                        report("final_result", 16'(m_tlast), 16'(want.fin));
                end
            end
        end
        awaited = expected_words.size();
    end

endmodule

// ===== sim/tb.sv =====
`timescale 1ns / 1ps

module tb;

    logic                           aclk;
    logic                           aresetn;
    logic                           cfg_valid;
    logic                           cfg_ready;
    logic [ttmd_pkg::CFG_IDX_W-1:0] cfg_index;
    logic [ttmd_pkg::MAP_W-1:0]     cfg_data;
    logic                           s_tvalid;
    logic                           s_tready;
    logic [ttmd_pkg::RAW_W-1:0]     s_tdata;   // [15:0] raw_sample
    logic                           s_tlast;   // end_of_stream
    logic                           m_tvalid;
    logic                           m_tready;
    logic [15:0]                    m_tdata;   // [8:0] clean_sample, rest zero
    logic                           m_tlast;   // final_result

    int mismatches;
    int awaited;
    int words_checked;
    int refills;

    logic        steady;
    int          limit_now;
    int          samples_sent;
    int          streams_run;
    logic [15:0] head_level;
    int          head_left [16];

    tape_track_map_and_deglitch_unit i_dut (.*);

    track_stream_checker i_chk (.*);

    always begin
        aclk = 1'b1;
        #5;
        aclk = 1'b0;
        #5;
    end

    // sink stalls now and then, never while steady
    always @(negedge aclk) begin
        m_tready = steady || ($urandom_range(0, 99) >= 9);
    end

    task automatic send_sample(input logic [ttmd_pkg::RAW_W-1:0] raw, input logic last);
        @(negedge aclk);
        while (!steady && $urandom_range(0, 99) < 9) begin
            s_tvalid = 1'b0;
            s_tdata  = 16'($urandom());
            s_tlast  = 1'($urandom());
            @(negedge aclk);
        end
        s_tvalid = 1'b1;
        s_tdata  = raw;
        s_tlast  = last;
        do @(posedge aclk); while (!s_tready);
        samples_sent++;
    endtask

    task automatic write_reg(input logic [ttmd_pkg::CFG_IDX_W-1:0] idx,
                             input logic [ttmd_pkg::MAP_W-1:0] value);
        @(negedge aclk);
        cfg_valid = 1'b1;
        cfg_index = idx;
        cfg_data  = value;
        do @(posedge aclk); while (!cfg_ready);
        @(negedge aclk);
        cfg_valid = 1'b0;
    endtask

    task automatic configure(input logic [ttmd_pkg::MAP_W-1:0] map, input int limit);
        logic [ttmd_pkg::MAP_W-1:0] word;
        write_reg(ttmd_pkg::REG_CHANNEL_MAP, map);
        // upper bits carry junk; only the low field counts
        word = {4'($urandom()), 32'($urandom())};
        word[ttmd_pkg::GLITCH_W-1:0] = ttmd_pkg::GLITCH_W'(limit);
        write_reg(ttmd_pkg::REG_GLITCH_MAX, word);
        limit_now = limit;
    endtask

    // wait for the drain to finish and the block to fall quiet
    task automatic settle();
        @(negedge aclk);
        s_tvalid = 1'b0;
        wait (awaited == 0);
        repeat (8) @(posedge aclk);
        streams_run++;
    endtask

    task automatic send_guard();
        repeat (ttmd_pkg::GUARD_DEF) send_sample(16'($urandom()), 1'b0);
    endtask

    // each head line runs as alternating low and high runs, lows sized around the limit
    function automatic logic [15:0] next_raw();
        int pick;
        if ($urandom_range(0, 9) == 0) return 16'($urandom());
        for (int b = 0; b < 16; b++) begin
            if (head_left[b] == 0) begin
                head_level[b] = !head_level[b];
                if (head_level[b]) begin
                    head_left[b] = $urandom_range(1, 6);
                end else begin
                    pick = $urandom_range(0, 9);
                    if (pick < 6) head_left[b] = $urandom_range(1, limit_now + 2);
                    else if (pick < 9) head_left[b] = $urandom_range(1, 6);
                    else head_left[b] = $urandom_range(30, 70);
                end
            end
            head_left[b]--;
        end
        return head_level;
    endfunction

    task automatic random_stream(input int len);
        head_level = '1;
        for (int b = 0; b < 16; b++) head_left[b] = $urandom_range(1, 4);
        for (int k = 0; k < len; k++) send_sample(next_raw(), k == len - 1);
        settle();
    endtask

    initial begin
        int len;
        aresetn      = 1'b0;
        cfg_valid    = 1'b0;
        cfg_index    = ttmd_pkg::REG_CHANNEL_MAP;
        cfg_data     = '0;
        s_tvalid     = 1'b0;
        s_tdata      = '0;
        s_tlast      = 1'b0;
        steady       = 1'b0;
        limit_now    = 0;
        samples_sent = 0;
        streams_run  = 0;
        repeat (7) @(posedge aclk);
        @(negedge aclk);
        aresetn = 1'b1;

        // one-sample stream ended inside the guard
        send_sample(16'hFFFF, 1'b1);
        settle();

        // reset map: a glitch at the limit, one just over it, an open run at the end
        configure(ttmd_pkg::MAP_RESET, 3);
        repeat (ttmd_pkg::GUARD_DEF) send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        repeat (3) send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        repeat (4) send_sample(16'h0000, 1'b0);
        send_sample(16'hFFFF, 1'b0);
        send_sample(16'h0000, 1'b0);
        send_sample(16'h0000, 1'b1);
        settle();

        // every track from raw bit 0; rising edge on the last sample
        configure('0, 31);
        send_guard();
        send_sample(16'h0001, 1'b0);
        repeat (2) send_sample(16'hFFFE, 1'b0);
        send_sample(16'h0001, 1'b1);
        settle();

        // every track from raw bit 15
        configure('1, 31);
        send_guard();
        send_sample(16'h8000, 1'b0);
        send_sample(16'h7FFF, 1'b0);
        send_sample(16'hFFFF, 1'b1);
        settle();

        for (int k = 0; samples_sent < 270; k++) begin
            steady = (k == 1);
            case (k % 4)
                0: configure({4'($urandom()), 32'($urandom())}, $urandom_range(1, 31));
                1: configure(ttmd_pkg::MAP_RESET, 31);
                2: configure({4'($urandom()), 32'($urandom())}, 0);
                default: configure({4'($urandom()), 32'($urandom())}, $urandom_range(2, 8));
            endcase
            len = (k % 5 == 4) ? $urandom_range(80, 140) : $urandom_range(8, 60);
            random_stream(ttmd_pkg::GUARD_DEF + len);
        end
        steady = 1'b0;

        wait (awaited == 0);
        repeat (ttmd_pkg::DELAY_DEPTH_DEF + 8) @(posedge aclk);

        $display("%0d samples sent in %0d streams, %0d results checked", samples_sent,
                 streams_run, words_checked);
        $display("%0d low runs refilled as glitches", refills);
        if (mismatches == 0) begin
            $display("No mismatches found");
        end else begin
            $display("Mismatches found");
        end
        $finish;
    end

    initial begin
        #2_000_000;
        $display("timeout with %0d results outstanding", awaited);
        $display("Mismatches found");
        $finish;
    end

endmodule

// ===== tape_track_map_and_deglitch_unit.f =====
rtl/ttmd_pkg.sv
rtl/ttmd_front.sv
rtl/ttmd_queue.sv
rtl/ttmd_back.sv
rtl/tape_track_map_and_deglitch_unit.sv
rtl/ttmd_checker.sv
sim/track_stream_checker.sv
sim/tb.sv
